// ===== rtl/core/fela_pkg.sv =====
// ----------------------------------------------------------------------------
// fela_pkg
// Request and status codes shared by the free extent list allocator.
// ----------------------------------------------------------------------------
package fela_pkg;

    localparam int unsigned FIELD_W = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVAL   = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

endpackage

// ===== rtl/core/fela_mem.sv =====
// ----------------------------------------------------------------------------
// fela_mem
// Simple dual-port memory holding the extent table, registered read data.
// ----------------------------------------------------------------------------
module fela_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/free_extent_list_allocator.sv =====
// ----------------------------------------------------------------------------
// free_extent_list_allocator
// Sorted table of disjoint free block ranges with merging insert and pop.
// ----------------------------------------------------------------------------
// An item arrives on the input channel (i_in_valid / o_in_ready) and yields
// exactly one result item on the output channel (o_out_valid / i_out_ready).
// One item is worked on at a time; the table lives in a single memory with
// registered read data, so each step of a scan or a shift is a read state
// followed by a check or write state. A clear, or a pop on an empty table,
// goes straight to the result. A pop reads the lowest range, then trims it,
// or removes it and shifts the later entries down when all of it is granted.
// An insert scans entries up to its place, decides, and shifts later entries
// up when a range is opened or down when two ranges are joined.
// The result sits in an output register, so the next item is accepted while
// a result still waits; a stalled receiver only holds the block once a second
// result is ready. Reset empties the table at once (the entry count is
// cleared); table contents need no clearing pass.
// ----------------------------------------------------------------------------
module free_extent_list_allocator #(
    parameter int unsigned MAX_RANGES = 64,
    parameter int unsigned BLOCK_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_range_start,
    input  logic [31:0] i_range_end,
    input  logic [31:0] i_want_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_alloc_start,
    output logic [31:0] o_granted_count
);

    localparam int unsigned BW   = BLOCK_BITS;
    localparam int unsigned EW   = 2 * BLOCK_BITS;
    localparam int unsigned AW   = $clog2(MAX_RANGES);
    localparam int unsigned CNTW = $clog2(MAX_RANGES + 1);
    localparam int unsigned CW   = ((BLOCK_BITS > 32) ? BLOCK_BITS : 32) + 1;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_SCAN_RD  = 11'b00000000010,
        S_SCAN_CHK = 11'b00000000100,
        S_DECIDE   = 11'b00000001000,
        S_SHUP_RD  = 11'b00000010000,
        S_SHUP_WR  = 11'b00000100000,
        S_SHDN_RD  = 11'b00001000000,
        S_SHDN_WR  = 11'b00010000000,
        S_POP_RD   = 11'b00100000000,
        S_POP_CHK  = 11'b01000000000,
        S_DONE     = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [CNTW-1:0] r_used, n_used;
    logic            r_out_valid, n_out_valid;

    logic [BW-1:0]   r_lo, n_lo, r_hi, n_hi;
    logic [31:0]     r_want, n_want;
    logic [CNTW-1:0] r_pos, n_pos, r_idx, n_idx;
    logic [BW-1:0]   r_prev_lo, n_prev_lo, r_prev_hi, n_prev_hi;
    logic [BW-1:0]   r_next_lo, n_next_lo, r_next_hi, n_next_hi;
    logic            r_has_next, n_has_next;
    logic [1:0]      r_res_status, n_res_status;
    logic [31:0]     r_res_start, n_res_start, r_res_granted, n_res_granted;
    logic [1:0]      r_out_status, n_out_status;
    logic [31:0]     r_out_start, n_out_start, r_out_granted, n_out_granted;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    fela_mem #(
        .DEPTH (MAX_RANGES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    logic [BW-1:0]   in_lo, in_hi, rd_lo, rd_hi, span, new_low;
    logic [CNTW-1:0] idx_p1, idx_m1, pos_m1;
    logic            ov_prev, ov_next, adj_prev, adj_next, has_prev, full;
    logic [CW-1:0]   want_e, span_e, grant_e;

    assign in_lo  = BW'(i_range_start);
    assign in_hi  = BW'(i_range_end);
    assign rd_lo  = mem_rdata[BW-1:0];
    assign rd_hi  = mem_rdata[EW-1:BW];
    assign idx_p1 = r_idx + 1'b1;
    assign idx_m1 = r_idx - 1'b1;
    assign pos_m1 = r_pos - 1'b1;

    assign has_prev = (r_pos != '0);
    assign full     = (r_used == CNTW'(MAX_RANGES));
    assign ov_prev  = has_prev && (r_prev_hi >= r_lo);
    assign ov_next  = r_has_next && (r_next_lo <= r_hi);
    // A range ending at the top block number is adjacent to nothing above it.
    assign adj_prev = has_prev && ({1'b0, r_prev_hi} + 1'b1 == {1'b0, r_lo});
    assign adj_next = r_has_next && ({1'b0, r_hi} + 1'b1 == {1'b0, r_next_lo});

    assign span    = rd_hi - rd_lo;
    assign want_e  = CW'(r_want);
    assign span_e  = CW'(span);
    assign grant_e = (r_want == '0) ? '0 :
                     ((want_e - 1'b1 <= span_e) ? want_e : span_e + 1'b1);
    assign new_low = rd_lo + grant_e[BW-1:0];

    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_out_valid   = r_out_valid;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_want        = r_want;
        n_pos         = r_pos;
        n_idx         = r_idx;
        n_prev_lo     = r_prev_lo;
        n_prev_hi     = r_prev_hi;
        n_next_lo     = r_next_lo;
        n_next_hi     = r_next_hi;
        n_has_next    = r_has_next;
        n_res_status  = r_res_status;
        n_res_start   = r_res_start;
        n_res_granted = r_res_granted;
        n_out_status  = r_out_status;
        n_out_start   = r_out_start;
        n_out_granted = r_out_granted;
        mem_we        = 1'b0;
        mem_waddr     = r_idx[AW-1:0];
        mem_wdata     = mem_rdata;
        mem_raddr     = r_idx[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_lo          = in_lo;
                    n_hi          = in_hi;
                    n_want        = i_want_count;
                    n_res_status  = fela_pkg::ST_OK;
                    n_res_start   = '0;
                    n_res_granted = '0;
                    n_idx         = '0;
                    n_pos         = '0;
                    n_has_next    = 1'b0;
                    n_state       = S_DONE;
                    case (i_req_type)
                        fela_pkg::REQ_INSERT: begin
                            if (in_hi < in_lo) begin
                                n_res_status = fela_pkg::ST_INVAL;
                            end else if (r_used == '0) begin
                                n_state = S_DECIDE;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        fela_pkg::REQ_POP: begin
                            if (r_used != '0) begin
                                n_state = S_POP_RD;
                            end
                        end
                        fela_pkg::REQ_CLEAR: begin
                            n_used = '0;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (rd_lo == r_lo) begin
                    n_res_status = fela_pkg::ST_INVAL;
                    n_state      = S_DONE;
                end else if (rd_lo < r_lo) begin
                    n_prev_lo = rd_lo;
                    n_prev_hi = rd_hi;
                    n_idx     = idx_p1;
                    if (idx_p1 < r_used) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_pos   = idx_p1;
                        n_state = S_DECIDE;
                    end
                end else begin
                    n_next_lo  = rd_lo;
                    n_next_hi  = rd_hi;
                    n_has_next = 1'b1;
                    n_pos      = r_idx;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (ov_prev || ov_next) begin
                    n_res_status = fela_pkg::ST_INVAL;
                end else if (adj_prev && adj_next) begin
                    // Bridge the hole: the predecessor absorbs the successor.
                    mem_we    = 1'b1;
                    mem_waddr = pos_m1[AW-1:0];
                    mem_wdata = {r_next_hi, r_prev_lo};
                    n_idx     = r_pos;
                    n_state   = S_SHDN_RD;
                end else if (adj_prev) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_m1[AW-1:0];
                    mem_wdata = {r_hi, r_prev_lo};
                end else if (adj_next) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = {r_next_hi, r_lo};
                end else if (full) begin
                    n_res_status = fela_pkg::ST_NOSPACE;
                end else begin
                    n_idx   = r_used;
                    n_state = S_SHUP_RD;
                end
            end
            S_SHUP_RD: begin
                mem_raddr = idx_m1[AW-1:0];
                if (r_idx == r_pos) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = {r_hi, r_lo};
                    n_used    = r_used + 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_SHUP_WR;
                end
            end
            S_SHUP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = idx_m1;
                n_state   = S_SHUP_RD;
            end
            S_SHDN_RD: begin
                mem_raddr = idx_p1[AW-1:0];
                if (idx_p1 >= r_used) begin
                    n_used  = r_used - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHDN_WR;
                end
            end
            S_SHDN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                n_idx     = idx_p1;
                n_state   = S_SHDN_RD;
            end
            S_POP_RD: begin
                mem_raddr = '0;
                n_state   = S_POP_CHK;
            end
            S_POP_CHK: begin
                n_res_start   = 32'(rd_lo);
                n_res_granted = 32'(grant_e);
                n_state       = S_DONE;
                if (grant_e != '0) begin
                    if (grant_e - 1'b1 == span_e) begin
                        n_idx   = '0;
                        n_state = S_SHDN_RD;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = {rd_hi, new_low};
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_start   = r_res_start;
                    n_out_granted = r_res_granted;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_want        <= n_want;
        r_pos         <= n_pos;
        r_idx         <= n_idx;
        r_prev_lo     <= n_prev_lo;
        r_prev_hi     <= n_prev_hi;
        r_next_lo     <= n_next_lo;
        r_next_hi     <= n_next_hi;
        r_has_next    <= n_has_next;
        r_res_status  <= n_res_status;
        r_res_start   <= n_res_start;
        r_res_granted <= n_res_granted;
        r_out_status  <= n_out_status;
        r_out_start   <= n_out_start;
        r_out_granted <= n_out_granted;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_alloc_start   = r_out_start;
    assign o_granted_count = r_out_granted;

endmodule
